// File: design/lds_pkg.sv
// Shared types and constants for the largest divisible subset unit.
// No dependencies; used by the controller, the datapath and the top level.
`default_nettype none

package lds_pkg;

  localparam int VALUE_W          = 31;
  localparam int STATUS_W         = 2;
  localparam int MAX_ELEMENTS_DEF = 64;

  // Status flag bit positions.
  localparam int FLAG_CAP  = 0;
  localparam int FLAG_ZERO = 1;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_CHECK,
    ST_SORT_KEY,
    ST_SORT_KEY_W,
    ST_SORT_RD,
    ST_SORT_CMP,
    ST_CLEAR,
    ST_COL,
    ST_COL_W,
    ST_ROW,
    ST_ROW_W,
    ST_DIV,
    ST_DEC,
    ST_WALK,
    ST_WALK_W,
    ST_FIN
  } state_t;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,
    OP_SETUP,
    OP_SORT_KEY_RD,
    OP_SORT_KEY_CAP,
    OP_SORT_PREV_RD,
    OP_SORT_SHIFT,
    OP_SORT_PLACE,
    OP_CLR,
    OP_COL_RD,
    OP_COL_CAP,
    OP_ROW_RD,
    OP_ROW_CAP,
    OP_DEC,
    OP_WALK_RD,
    OP_WALK_CAP,
    OP_FIN
  } op_t;

  typedef struct packed {
    logic n_zero;
    logic i_end;
    logic j_zero;
    logic prev_gt;
    logic clr_end;
    logic r_zero;
    logic c_zero;
    logic div_done;
    logic walk_end;
  } dp_stat_t;

endpackage

`default_nettype wire

// File: design/lds_divider.sv
// Restoring divider that reports whether the divisor divides the dividend.
// Depends on lds_pkg for the value width; one quotient bit per cycle.
`default_nettype none

module lds_divider (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        start,
  input  wire logic [lds_pkg::VALUE_W-1:0] dividend,
  input  wire logic [lds_pkg::VALUE_W-1:0] divisor,
  output logic                             done,
  output logic                             rem_zero
);

  localparam int VW = lds_pkg::VALUE_W;
  localparam int NW = $clog2(VW + 1);

  logic [NW-1:0] cnt;
  logic [VW-1:0] rem;
  logic [VW-1:0] shreg;
  logic [VW-1:0] bval;
  logic [VW:0]   trial;

  assign trial    = {rem, shreg[VW-1]};
  assign rem_zero = (rem == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else if (start) begin
      cnt  <= NW'(VW);
      done <= 1'b0;
    end else if (cnt != '0) begin
      cnt  <= cnt - 1'b1;
      done <= (cnt == NW'(1));
    end else begin
      done <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem   <= '0;
      shreg <= dividend;
      bval  <= divisor;
    end else if (cnt != '0) begin
      // The partial remainder stays below the divisor, so it fits the value width.
      if (trial >= {1'b0, bval}) begin
        rem <= VW'(trial - {1'b0, bval});
      end else begin
        rem <= trial[VW-1:0];
      end
      shreg <= {shreg[VW-2:0], 1'b0};
    end
  end

endmodule

`default_nettype wire

// File: design/lds_ctrl.sv
// Sequencer of the largest divisible subset unit: load, sort, solve, walk.
// Depends on lds_pkg for the state, operation and status types.
`default_nettype none

module lds_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  input  wire logic              last_in,
  input  wire lds_pkg::dp_stat_t stat,
  output lds_pkg::op_t           op,
  output logic                   busy
);

  lds_pkg::state_t state;
  lds_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lds_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      lds_pkg::ST_IDLE: begin
        if (start && last_in) state_next = lds_pkg::ST_CHECK;
      end
      lds_pkg::ST_CHECK: begin
        state_next = stat.n_zero ? lds_pkg::ST_FIN : lds_pkg::ST_SORT_KEY;
      end
      lds_pkg::ST_SORT_KEY: begin
        state_next = stat.i_end ? lds_pkg::ST_CLEAR : lds_pkg::ST_SORT_KEY_W;
      end
      lds_pkg::ST_SORT_KEY_W: state_next = lds_pkg::ST_SORT_RD;
      lds_pkg::ST_SORT_RD: begin
        state_next = stat.j_zero ? lds_pkg::ST_SORT_KEY : lds_pkg::ST_SORT_CMP;
      end
      lds_pkg::ST_SORT_CMP: begin
        state_next = stat.prev_gt ? lds_pkg::ST_SORT_RD : lds_pkg::ST_SORT_KEY;
      end
      lds_pkg::ST_CLEAR: begin
        if (stat.clr_end) state_next = lds_pkg::ST_COL;
      end
      lds_pkg::ST_COL:   state_next = lds_pkg::ST_COL_W;
      lds_pkg::ST_COL_W: state_next = lds_pkg::ST_ROW;
      lds_pkg::ST_ROW:   state_next = lds_pkg::ST_ROW_W;
      lds_pkg::ST_ROW_W: begin
        state_next = stat.r_zero ? lds_pkg::ST_DEC : lds_pkg::ST_DIV;
      end
      lds_pkg::ST_DIV: begin
        if (stat.div_done) state_next = lds_pkg::ST_DEC;
      end
      lds_pkg::ST_DEC: begin
        if (stat.r_zero && stat.c_zero) state_next = lds_pkg::ST_WALK;
        else if (stat.r_zero)           state_next = lds_pkg::ST_COL;
        else                            state_next = lds_pkg::ST_ROW;
      end
      lds_pkg::ST_WALK: begin
        state_next = stat.walk_end ? lds_pkg::ST_FIN : lds_pkg::ST_WALK_W;
      end
      lds_pkg::ST_WALK_W: state_next = lds_pkg::ST_WALK;
      lds_pkg::ST_FIN:    state_next = lds_pkg::ST_IDLE;
      default:            state_next = lds_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    op   = lds_pkg::OP_NONE;
    busy = 1'b1;
    case (state)
      lds_pkg::ST_IDLE: begin
        busy = 1'b0;
        if (start) op = lds_pkg::OP_LOAD;
      end
      lds_pkg::ST_CHECK: op = lds_pkg::OP_SETUP;
      lds_pkg::ST_SORT_KEY: begin
        if (!stat.i_end) op = lds_pkg::OP_SORT_KEY_RD;
      end
      lds_pkg::ST_SORT_KEY_W: op = lds_pkg::OP_SORT_KEY_CAP;
      lds_pkg::ST_SORT_RD: begin
        op = stat.j_zero ? lds_pkg::OP_SORT_PLACE : lds_pkg::OP_SORT_PREV_RD;
      end
      lds_pkg::ST_SORT_CMP: begin
        op = stat.prev_gt ? lds_pkg::OP_SORT_SHIFT : lds_pkg::OP_SORT_PLACE;
      end
      lds_pkg::ST_CLEAR: op = lds_pkg::OP_CLR;
      lds_pkg::ST_COL:   op = lds_pkg::OP_COL_RD;
      lds_pkg::ST_COL_W: op = lds_pkg::OP_COL_CAP;
      lds_pkg::ST_ROW:   op = lds_pkg::OP_ROW_RD;
      lds_pkg::ST_ROW_W: op = lds_pkg::OP_ROW_CAP;
      lds_pkg::ST_DIV:   op = lds_pkg::OP_NONE;
      lds_pkg::ST_DEC:   op = lds_pkg::OP_DEC;
      lds_pkg::ST_WALK: begin
        if (!stat.walk_end) op = lds_pkg::OP_WALK_RD;
      end
      lds_pkg::ST_WALK_W: op = lds_pkg::OP_WALK_CAP;
      lds_pkg::ST_FIN:    op = lds_pkg::OP_FIN;
      default:            op = lds_pkg::OP_NONE;
    endcase
  end

endmodule

`default_nettype wire

// File: design/lds_datapath.sv
// Datapath: element store, chain-length column, take marks, divider, result register.
// Depends on lds_pkg and lds_divider; driven one operation per cycle by lds_ctrl.
`default_nettype none

module lds_datapath #(
  parameter int MAX_ELEMENTS = lds_pkg::MAX_ELEMENTS_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire lds_pkg::op_t                 op,
  input  wire logic [lds_pkg::VALUE_W-1:0]  value,
  output lds_pkg::dp_stat_t                 stat,
  output logic                              result_strobe,
  output logic [lds_pkg::VALUE_W-1:0]       member,
  output logic                              last_out,
  output logic [lds_pkg::STATUS_W-1:0]      status
);

  localparam int VW         = lds_pkg::VALUE_W;
  localparam int EW         = $clog2(MAX_ELEMENTS);
  localparam int CW         = $clog2(MAX_ELEMENTS + 1);
  localparam int MARK_DEPTH = (MAX_ELEMENTS + 1) * MAX_ELEMENTS;
  localparam int MAW        = $clog2(MARK_DEPTH);

  logic [VW-1:0] elem_mem [MAX_ELEMENTS];
  logic [CW-1:0] col_mem  [MAX_ELEMENTS + 1];
  logic          mark_mem [MARK_DEPTH];

  logic [VW-1:0]  elem_rd;
  logic [CW-1:0]  col_rd;
  logic           mark_rd;

  logic [CW-1:0]  count;
  logic [lds_pkg::STATUS_W-1:0] flags;
  logic [CW-1:0]  i;
  logic [CW-1:0]  j;
  logic [CW-1:0]  c;
  logic [CW-1:0]  r;
  logic [CW-1:0]  row;
  logic [VW-1:0]  key;
  logic [VW-1:0]  dividend;
  logic [CW-1:0]  diag;
  logic [CW-1:0]  skip;
  logic [VW-1:0]  pend;
  logic           pend_valid;

  logic           div_start;
  logic           div_done;
  logic           div_rem_zero;

  logic           elem_we;
  logic [EW-1:0]  elem_waddr;
  logic [VW-1:0]  elem_wdata;
  logic [EW-1:0]  elem_raddr;
  logic           col_we;
  logic [CW-1:0]  col_waddr;
  logic [CW-1:0]  col_wdata;
  logic [CW-1:0]  col_raddr;
  logic [MAW-1:0] mark_waddr;
  logic [MAW-1:0] mark_raddr;
  logic [CW-1:0]  take;
  logic           take_wins;
  logic           load_store;

  lds_divider u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (dividend),
    .divisor  (elem_rd),
    .done     (div_done),
    .rem_zero (div_rem_zero)
  );

  assign div_start  = (op == lds_pkg::OP_ROW_CAP) && (r != '0);
  assign load_store = (value != '0) && (count != CW'(MAX_ELEMENTS));

  // Row zero means nothing taken yet, so any element may be taken there.
  assign take      = ((r == '0) || div_rem_zero) ? CW'(diag + 1'b1) : '0;
  assign take_wins = (take > skip);

  assign mark_waddr = MAW'(r) * MAW'(MAX_ELEMENTS) + MAW'(c);
  assign mark_raddr = MAW'(row) * MAW'(MAX_ELEMENTS) + MAW'(c);

  always_comb begin
    stat.n_zero   = (count == '0);
    stat.i_end    = (i >= count);
    stat.j_zero   = (j == '0);
    stat.prev_gt  = (elem_rd > key);
    stat.clr_end  = (r == count);
    stat.r_zero   = (r == '0);
    stat.c_zero   = (c == '0);
    stat.div_done = div_done;
    stat.walk_end = (c >= count);
  end

  always_comb begin
    elem_we    = 1'b0;
    elem_waddr = count[EW-1:0];
    elem_wdata = value;
    elem_raddr = c[EW-1:0];
    col_we     = 1'b0;
    col_waddr  = r;
    col_wdata  = '0;
    col_raddr  = r;
    case (op)
      lds_pkg::OP_LOAD: begin
        elem_we = load_store;
      end
      lds_pkg::OP_SORT_KEY_RD:  elem_raddr = i[EW-1:0];
      lds_pkg::OP_SORT_PREV_RD: elem_raddr = EW'(j - 1'b1);
      lds_pkg::OP_SORT_SHIFT: begin
        elem_we    = 1'b1;
        elem_waddr = j[EW-1:0];
        elem_wdata = elem_rd;
      end
      lds_pkg::OP_SORT_PLACE: begin
        elem_we    = 1'b1;
        elem_waddr = j[EW-1:0];
        elem_wdata = key;
      end
      lds_pkg::OP_CLR: begin
        col_we = 1'b1;
      end
      lds_pkg::OP_COL_RD: begin
        elem_raddr = c[EW-1:0];
        col_raddr  = CW'(c + 1'b1);
      end
      lds_pkg::OP_ROW_RD: begin
        elem_raddr = EW'(r - 1'b1);
        col_raddr  = r;
      end
      lds_pkg::OP_DEC: begin
        col_we    = 1'b1;
        col_wdata = take_wins ? take : skip;
      end
      lds_pkg::OP_WALK_RD: elem_raddr = c[EW-1:0];
      default: begin
        elem_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (elem_we) elem_mem[elem_waddr] <= elem_wdata;
    elem_rd <= elem_mem[elem_raddr];
  end

  always_ff @(posedge clk) begin
    if (col_we) col_mem[col_waddr] <= col_wdata;
    col_rd <= col_mem[col_raddr];
  end

  // Every mark with row not above column is rewritten in each solve, and the
  // walk reads no other, so the mark store needs no clearing pass.
  always_ff @(posedge clk) begin
    if (op == lds_pkg::OP_DEC) mark_mem[mark_waddr] <= take_wins;
    mark_rd <= mark_mem[mark_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count         <= '0;
      flags         <= '0;
      pend_valid    <= 1'b0;
      result_strobe <= 1'b0;
    end else begin
      case (op)
        lds_pkg::OP_LOAD: begin
          result_strobe <= 1'b0;
          if (value == '0) begin
            flags[lds_pkg::FLAG_ZERO] <= 1'b1;
          end else if (count == CW'(MAX_ELEMENTS)) begin
            flags[lds_pkg::FLAG_CAP] <= 1'b1;
          end else begin
            count <= count + 1'b1;
          end
        end
        lds_pkg::OP_SETUP: begin
          result_strobe <= 1'b0;
          pend_valid    <= (count == '0);
        end
        lds_pkg::OP_DEC: begin
          result_strobe <= 1'b0;
          if ((r == '0) && (c == '0)) pend_valid <= 1'b0;
        end
        lds_pkg::OP_WALK_CAP: begin
          result_strobe <= mark_rd && pend_valid;
          if (mark_rd) pend_valid <= 1'b1;
        end
        lds_pkg::OP_FIN: begin
          result_strobe <= pend_valid;
          pend_valid    <= 1'b0;
          count         <= '0;
          flags         <= '0;
        end
        default: begin
          result_strobe <= 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (op)
      lds_pkg::OP_SETUP: begin
        i    <= CW'(1);
        r    <= '0;
        pend <= '0;
      end
      lds_pkg::OP_SORT_KEY_CAP: begin
        key <= elem_rd;
        j   <= i;
      end
      lds_pkg::OP_SORT_SHIFT: j <= j - 1'b1;
      lds_pkg::OP_SORT_PLACE: i <= i + 1'b1;
      lds_pkg::OP_CLR: begin
        if (r == count) c <= count - 1'b1;
        else            r <= r + 1'b1;
      end
      lds_pkg::OP_COL_CAP: begin
        dividend <= elem_rd;
        diag     <= col_rd;
        r        <= c;
      end
      lds_pkg::OP_ROW_CAP: skip <= col_rd;
      lds_pkg::OP_DEC: begin
        if (r != '0) begin
          r <= r - 1'b1;
        end else if (c != '0) begin
          c <= c - 1'b1;
        end else begin
          row <= '0;
        end
      end
      lds_pkg::OP_WALK_CAP: begin
        if (mark_rd) begin
          member   <= pend;
          last_out <= 1'b0;
          status   <= flags;
          pend     <= elem_rd;
          row      <= CW'(c + 1'b1);
        end
        c <= c + 1'b1;
      end
      lds_pkg::OP_FIN: begin
        member   <= pend;
        last_out <= 1'b1;
        status   <= flags;
      end
      default: begin
        key <= key;
      end
    endcase
  end

endmodule

`default_nettype wire

// File: design/largest_divisible_subset_unit.sv
// Top level of the largest divisible subset unit.
// Depends on lds_pkg, lds_ctrl and lds_datapath (which holds lds_divider).
//
//   Channel   Ports                            Handshake
//   input     value, last_in                   start high while busy low
//   result    member, last_out, status         result_strobe, one cycle each
//
// After the word marked last the unit is busy: an insertion sort, a clear of
// the chain-length column, then a divisibility test by the bit-serial divider
// for each element pair that needs one, and a walk over the elements. Reset
// is synchronous and clears the controller, counts, flags and strobe. The
// receiver cannot stall: each result word is shown for exactly one cycle.
`default_nettype none

module largest_divisible_subset_unit #(
  parameter int MAX_ELEMENTS = lds_pkg::MAX_ELEMENTS_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             start,
  output logic                                  busy,
  input  wire logic [lds_pkg::VALUE_W-1:0]      value,
  input  wire logic                             last_in,
  output logic                                  result_strobe,
  output logic [lds_pkg::VALUE_W-1:0]           member,
  output logic                                  last_out,
  output logic [lds_pkg::STATUS_W-1:0]          status
);

  lds_pkg::op_t      op;
  lds_pkg::dp_stat_t stat;

  // The controller sequences the phases; the datapath holds all storage.
  lds_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .last_in (last_in),
    .stat    (stat),
    .op      (op),
    .busy    (busy)
  );

  lds_datapath #(
    .MAX_ELEMENTS (MAX_ELEMENTS)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .op            (op),
    .value         (value),
    .stat          (stat),
    .result_strobe (result_strobe),
    .member        (member),
    .last_out      (last_out),
    .status        (status)
  );

endmodule

`default_nettype wire
